// ===== rtl/datd_pkg.sv =====
// Shared types and constants for the delta address table decoder.
// No dependencies.
`default_nettype none
package datd_pkg;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgPointerSize = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgEntryCount  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFlatMode    = 2'd2;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusTrunc    = 2'd1;
  localparam logic [1:0] StatusTrailing = 2'd2;

  // byte moved from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  // result of one byte
  typedef struct packed {
    logic        entry_valid;
    logic [63:0] entry_id;
    logic [63:0] entry_offset;
    logic        stream_done;
    logic [1:0]  stream_status;
  } result_t;

  function automatic logic [3:0] kind_bytes(input logic [3:0] kind);
    logic [3:0] n;
    unique case (kind)
      4'd0: n = 4'd8;
      4'd2, 4'd3: n = 4'd1;
      4'd4, 4'd5, 4'd6: n = 4'd2;
      4'd7: n = 4'd4;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [63:0] kind_value(input logic [3:0] kind,
                                             input logic [63:0] p,
                                             input logic [63:0] v);
    logic [63:0] r;
    unique case (kind)
      4'd0, 4'd6, 4'd7: r = v;
      4'd1: r = p + 64'd1;
      4'd2, 4'd4: r = p + v;
      4'd3, 4'd5: r = p - v;
      default: r = p;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/datd_fifo.sv =====
// Small beat queue between the byte front end and the decode engine.
// Depends on datd_pkg.
`default_nettype none
module datd_fifo
  import datd_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   in_valid_i,
  output logic  in_ready_o,
  input  beat_t in_beat_i,
  output logic  out_valid_o,
  input  wire   out_ready_i,
  output beat_t out_beat_o
);
  beat_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_beat_o  = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_beat_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !pop) else $error("pop from empty queue");
endmodule
`default_nettype wire

// ===== rtl/datd_engine.sv =====
// Decode engine: parses delta or flat entries, scales offsets through a
// serial divider and a shift-add multiplier. Depends on datd_pkg.
`default_nettype none
module datd_engine
  import datd_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire   [7:0] pointer_size_i,
  input  wire  [30:0] entry_count_i,
  input  wire         flat_mode_i,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  beat_t       in_beat_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output result_t     out_res_o
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiv  = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StOut  = 3'd3;

  logic [2:0]  st_q, st_d;
  logic [63:0] prev_id_q, prev_id_d, prev_off_q, prev_off_d;
  logic [63:0] acc_q, acc_d, held_id_q, held_id_d;
  logic [1:0]  phase_q, phase_d;
  logic [3:0]  left_q, left_d, id_kind_q, id_kind_d;
  logic [2:0]  pos_q, pos_d, off_kind_q, off_kind_d;
  logic        scale_q, scale_d, trail_q, trail_d, last_q, last_d;
  logic [30:0] done_q, done_d;
  logic [5:0]  it_q, it_d;
  logic [63:0] quo_q, quo_d, mul_q, mul_d, prod_q, prod_d;
  logic [7:0]  rem_q, rem_d, ps_q, ps_d;
  result_t     res_q, res_d;

  logic [7:0]  ps;
  logic [8:0]  rem_sh;
  logic [63:0] acc_new;
  logic        take;

  assign ps = (pointer_size_i == 8'd0) ? 8'd1 : pointer_size_i;
  assign in_ready_o = (st_q == StIdle);
  assign out_valid_o = (st_q == StOut);
  assign out_res_o = res_q;
  assign take = in_valid_i && in_ready_o;
  assign acc_new = acc_q | ({56'd0, in_beat_i.data} << {pos_q, 3'd0});
  assign rem_sh = {rem_q, quo_q[63]};

  always_comb begin
    logic [63:0] hid, off, q;
    logic [3:0]  n;
    logic        have, fin, scl, sf;
    logic [30:0] dn;
    logic [1:0]  p2;
    logic [2:0]  okind;
    st_d = st_q; prev_id_d = prev_id_q; prev_off_d = prev_off_q; acc_d = acc_q;
    held_id_d = held_id_q; phase_d = phase_q; left_d = left_q; id_kind_d = id_kind_q;
    pos_d = pos_q; off_kind_d = off_kind_q; scale_d = scale_q; trail_d = trail_q;
    last_d = last_q; done_d = done_q; it_d = it_q; quo_d = quo_q; mul_d = mul_q;
    prod_d = prod_q; rem_d = rem_q; ps_d = ps_q; res_d = res_q;
    hid = held_id_q; off = '0; q = '0; n = 4'd0; have = 1'b0; fin = 1'b0;
    scl = 1'b0; sf = scale_q; dn = done_q; p2 = pos_q[1:0]; okind = off_kind_q;
    unique case (st_q)
      StIdle: begin
        if (take) begin
          if (trail_q || done_q >= entry_count_i) begin
            trail_d = 1'b1;
          end else if (flat_mode_i) begin
            q = ((p2 == 2'd0) ? 64'd0 : acc_q) | ({56'd0, in_beat_i.data} << {p2, 3'd0});
            if (p2 != 2'd3) begin
              acc_d = q; pos_d = {1'b0, p2 + 2'd1};
            end else begin
              acc_d = '0; pos_d = '0;
              hid = {33'd0, done_q}; off = {32'd0, q[31:0]};
              have = (q[31:0] != 32'd0); dn = done_q + 31'd1;
            end
          end else if (phase_q == 2'd1 || phase_q == 2'd2) begin
            acc_d = acc_new; pos_d = pos_q + 3'd1;
            n = (left_q != 4'd0) ? left_q - 4'd1 : 4'd0;
            left_d = n;
            if (n == 4'd0) begin
              if (phase_q == 2'd1) begin
                hid = kind_value(id_kind_q, prev_id_q, acc_new);
                held_id_d = hid;
                n = kind_bytes({1'b0, off_kind_q});
                acc_d = '0; pos_d = '0; left_d = n;
                if (n == 4'd0) fin = 1'b1; else phase_d = 2'd2;
              end else begin
                fin = 1'b1; q = acc_new;
              end
            end
          end else begin
            id_kind_d = in_beat_i.data[3:0];
            off_kind_d = in_beat_i.data[6:4];
            scale_d = in_beat_i.data[7];
            okind = in_beat_i.data[6:4];
            sf = in_beat_i.data[7];
            n = kind_bytes(in_beat_i.data[3:0]);
            acc_d = '0; pos_d = '0; left_d = n;
            if (n == 4'd0) begin
              hid = kind_value(in_beat_i.data[3:0], prev_id_q, 64'd0);
              held_id_d = hid;
              n = kind_bytes({1'b0, in_beat_i.data[6:4]});
              left_d = n;
              if (n == 4'd0) fin = 1'b1; else phase_d = 2'd2;
            end else phase_d = 2'd1;
          end
          if (fin) begin
            scl = sf;
            off = kind_value({1'b0, okind}, prev_off_q, q);
            have = 1'b1; dn = done_q + 31'd1;
            prev_id_d = hid; phase_d = 2'd0;
            mul_d = q;
            if (!scl) prev_off_d = off;
          end
          done_d = dn;
          last_d = in_beat_i.last;
          res_d.entry_valid = have;
          res_d.entry_id = have ? hid : 64'd0;
          res_d.entry_offset = have ? off : 64'd0;
          res_d.stream_done = in_beat_i.last;
          res_d.stream_status = !in_beat_i.last ? StatusOk :
            (trail_q || done_q >= entry_count_i) ? StatusTrailing :
            (dn < entry_count_i) ? StatusTrunc : StatusOk;
          quo_d = prev_off_q; rem_d = '0; ps_d = ps; it_d = '0; prod_d = '0;
          if (in_beat_i.last) begin
            phase_d = '0; acc_d = '0; left_d = '0; pos_d = '0;
            id_kind_d = '0; scale_d = 1'b0;
            held_id_d = '0; done_d = '0; trail_d = 1'b0;
            if (!scl) begin
              prev_id_d = '0; prev_off_d = '0; off_kind_d = '0;
            end
          end
          if (scl) st_d = StDiv;
          else if (have || in_beat_i.last) st_d = StOut;
        end
      end
      // restoring division of the previous offset by the pointer size
      StDiv: begin
        it_d = it_q + 6'd1;
        if (rem_sh >= {1'b0, ps_q}) begin
          rem_d = 8'(rem_sh - {1'b0, ps_q});
          quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = rem_sh[7:0];
          quo_d = {quo_q[62:0], 1'b0};
        end
        if (it_q == 6'd63) begin
          it_d = '0; st_d = StMul;
        end
      end
      // apply the kind to the quotient, then shift-add multiply
      StMul: begin
        it_d = it_q + 6'd1;
        if (it_q == 6'd0)
          mul_d = kind_value({1'b0, off_kind_q}, quo_q, mul_q);
        else if (ps_q[3'(8 - it_q)])
          prod_d = prod_q + (mul_q << (3'(8 - it_q)));
        if (it_q == 6'd7) begin
          q = (ps_q[0] ? mul_q : 64'd0) + prod_q
              + (ps_q[1] ? (mul_q << 1) : 64'd0);
          res_d.entry_offset = q;
          if (last_q) begin
            prev_off_d = '0; prev_id_d = '0; off_kind_d = '0;
          end else prev_off_d = q;
          st_d = StOut;
        end
      end
      StOut: if (out_ready_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; prev_id_q <= '0; prev_off_q <= '0; acc_q <= '0;
      held_id_q <= '0; phase_q <= '0; left_q <= '0; id_kind_q <= '0;
      pos_q <= '0; off_kind_q <= '0; scale_q <= 1'b0; trail_q <= 1'b0;
      last_q <= 1'b0; done_q <= '0; it_q <= '0; quo_q <= '0; mul_q <= '0;
      prod_q <= '0; rem_q <= '0; ps_q <= '0; res_q <= '0;
    end else begin
      st_q <= st_d; prev_id_q <= prev_id_d; prev_off_q <= prev_off_d; acc_q <= acc_d;
      held_id_q <= held_id_d; phase_q <= phase_d; left_q <= left_d; id_kind_q <= id_kind_d;
      pos_q <= pos_d; off_kind_q <= off_kind_d; scale_q <= scale_d; trail_q <= trail_d;
      last_q <= last_d; done_q <= done_d; it_q <= it_d; quo_q <= quo_d; mul_q <= mul_d;
      prod_q <= prod_d; rem_q <= rem_d; ps_q <= ps_d; res_q <= res_d;
    end
  end

  a_in_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> st_q == StIdle) else $error("byte taken while busy");
  a_div_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StDiv && it_q == 6'd63 |=> st_q == StMul) else $error("divide overrun");
  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !res_q.stream_done |-> res_q.stream_status == StatusOk)
    else $error("status without done");
endmodule
`default_nettype wire

// ===== rtl/delta_address_table_decoder_top.sv =====
// Top level of the delta address table decoder: config registers, beat
// queue and decode engine. Depends on datd_pkg, datd_fifo, datd_engine.
`default_nettype none
// Takes one table body byte per beat and returns a result beat for every
// byte that completes an entry or is marked tlast; tuser flags a result beat
// that carries an entry. A two-entry queue sits between the byte input and
// the decode engine. The engine takes a new byte only while idle. A byte
// that yields no result leaves it idle; an unscaled entry or end of body goes
// to the result beat, which holds until accepted; a byte that completes a
// scaled entry passes through the serial divider and the multiplier first.
module delta_address_table_decoder_top
  import datd_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          cfg_we_i,
  input  wire    [1:0] cfg_idx_i,
  input  wire   [30:0] cfg_data_i,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire    [7:0] s_axis_tdata,   // data_byte
  input  wire          s_axis_tlast,   // last_byte
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [135:0] m_axis_tdata,   // entry_id, entry_offset, stream_status
  output logic         m_axis_tuser,   // entry_valid
  output logic         m_axis_tlast    // stream_done
);
  logic [7:0]  ps_q;
  logic [30:0] cnt_q;
  logic        flat_q;
  logic        q_valid, q_ready;
  beat_t       q_beat, in_beat;
  result_t     res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q <= 8'd8; cnt_q <= '0; flat_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPointerSize: ps_q <= cfg_data_i[7:0];
        CfgEntryCount: cnt_q <= cfg_data_i;
        CfgFlatMode: flat_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_beat.data = s_axis_tdata;
  assign in_beat.last = s_axis_tlast;

  datd_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_beat_i(in_beat),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_beat_o(q_beat)
  );

  datd_engine u_engine (
    .clk_i, .rst_ni,
    .pointer_size_i(ps_q), .entry_count_i(cnt_q), .flat_mode_i(flat_q),
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_beat_i(q_beat),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_res_o(res)
  );

  assign m_axis_tdata = {6'd0, res.stream_status, res.entry_offset, res.entry_id};
  assign m_axis_tuser = res.entry_valid;
  assign m_axis_tlast = res.stream_done;
endmodule
`default_nettype wire

// ===== dv/delta_address_table_decoder_top_tb.sv =====
// Testbench for delta_address_table_decoder_top: random and directed table bodies
// are checked beat by beat against an in-bench decoder model.
// Depends on datd_pkg and the RTL of the decoder.
`default_nettype none
module delta_address_table_decoder_top_tb;
  import datd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned SettleCycles = 120;
  localparam int unsigned ItemTarget = 750;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [1:0]   cfg_idx_i;
  logic [30:0]  cfg_data_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [135:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;

  delta_address_table_decoder_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  // configuration copy
  logic [7:0]  psize_cfg;
  logic [30:0] ent_count;
  logic        flat;

  // decoder state copy
  logic [63:0] prev_id, prev_off, acc, held_id;
  logic [1:0]  phase;
  logic [3:0]  bytes_left, id_kind;
  logic [2:0]  byte_pos, off_kind;
  logic        scaled, trail;
  logic [30:0] done_cnt;
  logic        have_entry;
  logic [63:0] out_id, out_off;

  beat_t   pending_bytes[$];
  result_t expected_results[$];
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned items_queued;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [3:0] field_len(input logic [3:0] kind);
    case (kind)
      4'd0: return 4'd8;
      4'd2, 4'd3: return 4'd1;
      4'd4, 4'd5, 4'd6: return 4'd2;
      4'd7: return 4'd4;
      default: return 4'd0;
    endcase
  endfunction

  function automatic logic [63:0] coded_value(input logic [3:0] kind, input logic [63:0] p,
                                              input logic [63:0] v);
    case (kind)
      4'd0, 4'd6, 4'd7: return v;
      4'd1: return p + 64'd1;
      4'd2, 4'd4: return p + v;
      4'd3, 4'd5: return p - v;
      default: return p;
    endcase
  endfunction

  task automatic clear_decoder();
    prev_id = '0; prev_off = '0; acc = '0; held_id = '0; phase = '0;
    bytes_left = '0; id_kind = '0; byte_pos = '0; off_kind = '0;
    scaled = 1'b0; trail = 1'b0; done_cnt = '0;
  endtask

  task automatic close_entry();
    logic [63:0] ps, base, o;
    ps = (psize_cfg == 8'd0) ? 64'd1 : {56'd0, psize_cfg};
    base = scaled ? prev_off / ps : prev_off;
    o = coded_value({1'b0, off_kind}, base, acc);
    if (scaled) o = o * ps;
    have_entry = 1'b1; out_id = held_id; out_off = o;
    prev_id = held_id; prev_off = o;
    done_cnt = done_cnt + 31'd1;
    phase = 2'd0;
  endtask

  task automatic close_id();
    logic [3:0] n;
    held_id = coded_value(id_kind, prev_id, acc);
    n = field_len({1'b0, off_kind});
    acc = '0; byte_pos = '0; bytes_left = n;
    if (n == 4'd0) close_entry();
    else phase = 2'd2;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic [1:0]  p2;
    logic [3:0]  n;
    result_t     r;
    have_entry = 1'b0; out_id = '0; out_off = '0;
    if (trail || done_cnt >= ent_count) begin
      trail = 1'b1;
    end else if (flat) begin
      p2 = byte_pos[1:0];
      acc = ((p2 == 2'd0) ? 64'd0 : acc) | ({56'd0, b} << (8 * p2));
      if (p2 != 2'd3) begin
        byte_pos = {1'b0, p2} + 3'd1;
      end else begin
        byte_pos = '0;
        if (acc[31:0] != 32'd0) begin
          have_entry = 1'b1; out_id = {33'd0, done_cnt}; out_off = {32'd0, acc[31:0]};
        end
        acc = '0;
        done_cnt = done_cnt + 31'd1;
      end
    end else if (phase == 2'd1 || phase == 2'd2) begin
      acc = acc | ({56'd0, b} << (8 * byte_pos));
      byte_pos = byte_pos + 3'd1;
      if (bytes_left != 4'd0) bytes_left = bytes_left - 4'd1;
      if (bytes_left == 4'd0) begin
        if (phase == 2'd1) close_id();
        else close_entry();
      end
    end else begin
      id_kind = b[3:0]; off_kind = b[6:4]; scaled = b[7];
      n = field_len(id_kind);
      acc = '0; byte_pos = '0; bytes_left = n;
      if (n == 4'd0) close_id();
      else phase = 2'd1;
    end
    if (have_entry || last) begin
      r.entry_valid = have_entry;
      r.entry_id = out_id;
      r.entry_offset = out_off;
      r.stream_done = last;
      r.stream_status = StatusOk;
      if (last) begin
        if (trail) r.stream_status = StatusTrailing;
        else if (done_cnt < ent_count) r.stream_status = StatusTrunc;
        clear_decoder();
      end
      expected_results.insert(expected_results.size(), r);
    end
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  // driver
  int unsigned burst_left, gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tlast <= 1'b0;
      burst_left = 4;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          beat_t nb;
          nb = pending_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= nb.data;
          s_axis_tlast <= nb.last;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int unsigned stall_mode, mode_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_mode = 0;
      mode_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report("unexpected beat", m_axis_tdata[63:0], 64'd0);
        end else begin
          result_t w;
          w = expected_results.pop_front();
          if (m_axis_tuser !== w.entry_valid)
            report("entry_valid", 64'(m_axis_tuser), 64'(w.entry_valid));
          if (m_axis_tdata[63:0] !== w.entry_id)
            report("entry_id", m_axis_tdata[63:0], w.entry_id);
          if (m_axis_tdata[127:64] !== w.entry_offset)
            report("entry_offset", m_axis_tdata[127:64], w.entry_offset);
          if (m_axis_tdata[129:128] !== w.stream_status)
            report("stream_status", 64'(m_axis_tdata[129:128]), 64'(w.stream_status));
          if (m_axis_tlast !== w.stream_done)
            report("stream_done", 64'(m_axis_tlast), 64'(w.stream_done));
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(8, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_field(input int n, ref logic [7:0] body[$]);
    int unsigned cls;
    cls = $urandom_range(0, 3);
    for (int i = 0; i < n; i++)
      body.insert(body.size(),
                  cls == 0 ? 8'h00 : cls == 1 ? 8'hFF : 8'($urandom_range(0, 255)));
  endtask

  task automatic push_entry(input logic [7:0] ctl, ref logic [7:0] body[$]);
    body.insert(body.size(), ctl);
    push_field(int'(field_len(ctl[3:0])), body);
    push_field(int'(field_len({1'b0, ctl[6:4]})), body);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [30:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // send one body under the given settings; shape: 0 exact, 1 cut short, 2 extra bytes
  task automatic run_body(input logic [7:0] ps, input logic [30:0] cnt, input logic fm,
                          ref logic [7:0] body[$], input int shape);
    beat_t bt;
    if (shape == 1 && body.size() > 1) begin
      int drop;
      drop = $urandom_range(1, body.size() - 1);
      repeat (drop) void'(body.pop_back());
    end else if (shape == 2) begin
      repeat ($urandom_range(1, 4)) body.insert(body.size(), 8'($urandom_range(0, 255)));
    end
    if (body.size() == 0) body.insert(body.size(), 8'($urandom_range(0, 255)));
    wait_idle();
    cfg_write(CfgPointerSize, {23'd0, ps});
    cfg_write(CfgEntryCount, cnt);
    cfg_write(CfgFlatMode, {30'd0, fm});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    psize_cfg = ps; ent_count = cnt; flat = fm;
    foreach (body[i]) begin
      bt.data = body[i];
      bt.last = (i == body.size() - 1);
      pending_bytes.insert(pending_bytes.size(), bt);
    end
    items_queued += body.size();
  endtask

  initial begin
    logic [7:0] body[$];
    logic [7:0] ps;
    int n, shape;
    logic fm;
    mismatches = 0; cycles = 0; items_queued = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    psize_cfg = 8'd8; ent_count = '0; flat = 1'b0;
    clear_decoder();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // kinds 0 to 7 in both fields, then three scaled entries
    body.delete();
    push_entry(8'h00, body); push_entry(8'h11, body); push_entry(8'h22, body);
    push_entry(8'h33, body); push_entry(8'h44, body); push_entry(8'h55, body);
    push_entry(8'h66, body); push_entry(8'h77, body); push_entry(8'hF8, body);
    push_entry(8'h8F, body); push_entry(8'hA3, body);
    run_body(8'd8, 31'd11, 1'b0, body, 0);
    body.delete(); push_entry(8'hC5, body); push_entry(8'hD0, body);
    run_body(8'd0, 31'd2, 1'b0, body, 0);
    body.delete(); push_entry(8'hB7, body);
    run_body(8'd255, 31'd1, 1'b0, body, 2);
    body.delete(); push_entry(8'h90, body);
    run_body(8'd1, 31'h7FFFFFFF, 1'b0, body, 1);
    body.delete(); body.insert(body.size(), 8'hFF); body.insert(body.size(), 8'h00);
    run_body(8'd8, 31'd0, 1'b0, body, 0);
    body.delete();
    for (int i = 0; i < 3; i++) begin
      repeat (4) body.insert(body.size(), 8'hFF);
      repeat (4) body.insert(body.size(), 8'h00);
    end
    run_body(8'd8, 31'd6, 1'b1, body, 0);

    while (items_queued < ItemTarget) begin
      body.delete();
      case ($urandom_range(0, 4))
        0: ps = 8'd0;
        1: ps = 8'd1;
        2: ps = 8'd255;
        default: ps = 8'($urandom_range(2, 254));
      endcase
      fm = ($urandom_range(0, 3) == 0);
      n = $urandom_range(1, 6);
      shape = $urandom_range(0, 5);
      shape = (shape < 4) ? 0 : shape - 3;
      for (int i = 0; i < n; i++) begin
        if (fm) begin
          if ($urandom_range(0, 2) == 0) repeat (4) body.insert(body.size(), 8'h00);
          else push_field(4, body);
        end else begin
          push_entry(8'($urandom_range(0, 255)), body);
        end
      end
      if ($urandom_range(0, 9) == 0)
        run_body(ps, 31'(n + $urandom_range(1, 3)), fm, body, 0);
      else
        run_body(ps, 31'(n), fm, body, shape);
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire
